/* hdl/v3a_pkg.sv */
// Shared types, constants and helper functions of the three-component vector unit.
package v3a_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int DATA_W     = 32;
    localparam int OP_W       = 4;
    localparam int PROD_W     = 2 * DATA_W;
    localparam int ACC_W      = PROD_W + 2;
    localparam int NUM_W      = DATA_W + 1 + FRAC_BITS;
    localparam int SQRT_STEPS = DATA_W;
    localparam int DIV_STEPS  = DATA_W;
    localparam int SIDE_LEN   = SQRT_STEPS + 2 + DIV_STEPS;
    localparam int IN_DATA_W  = 7 * DATA_W;
    localparam int OUT_DATA_W = 4 * DATA_W;

    typedef logic signed [DATA_W-1:0] word_t;

    localparam word_t WORD_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam word_t WORD_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 4'd0,
        OP_SUB    = 4'd1,
        OP_SCALE  = 4'd2,
        OP_DIV    = 4'd3,
        OP_DOT    = 4'd4,
        OP_CROSS  = 4'd5,
        OP_LENSQ  = 4'd6,
        OP_LEN    = 4'd7,
        OP_NORM   = 4'd8
    } op_t;

    typedef struct packed {
        logic  sat;
        word_t val;
    } satw_t;

    // Work carried alongside the square root and divider pipelines.
    typedef struct packed {
        op_t         op;
        word_t [2:0] vec;
        logic        vsat;
        word_t       sc;
        logic        scsat;
        word_t [2:0] a;
        word_t       s;
        logic        sq_zero;
    } side_t;

    function automatic satw_t sat_acc(input logic signed [ACC_W-1:0] x);
        satw_t r;
        if ((&x[ACC_W-1:DATA_W-1]) || !(|x[ACC_W-1:DATA_W-1])) begin
            r.sat = 1'b0;
            r.val = x[DATA_W-1:0];
        end else begin
            r.sat = 1'b1;
            r.val = x[ACC_W-1] ? WORD_MIN : WORD_MAX;
        end
        return r;
    endfunction

    // Round to nearest with ties toward plus infinity, then drop the fraction bits.
    function automatic logic signed [ACC_W-1:0] rnd_shift(input logic signed [ACC_W-1:0] x);
        logic signed [ACC_W-1:0] t;
        t = x + {{(ACC_W-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};
        return t >>> FRAC_BITS;
    endfunction

    function automatic logic [DATA_W-1:0] mag(input word_t v);
        return v[DATA_W-1] ? DATA_W'(-v) : DATA_W'(v);
    endfunction

    function automatic satw_t quot_clamp(input logic [DATA_W-1:0] q, input logic ovf,
                                         input logic neg);
        satw_t r;
        r.sat = 1'b0;
        if (neg) begin
            if (ovf || (q > DATA_W'(WORD_MIN))) begin
                r.sat = 1'b1;
                r.val = WORD_MIN;
            end else begin
                r.val = word_t'(-q);
            end
        end else begin
            if (ovf || q[DATA_W-1]) begin
                r.sat = 1'b1;
                r.val = WORD_MAX;
            end else begin
                r.val = word_t'(q);
            end
        end
        return r;
    endfunction

endpackage

/* hdl/vec3_arith_unit_core.sv */
// Top level of the three-component fixed-point vector unit.
//
//  Channel  | Direction | Handshake         | Contents
//  ---------+-----------+-------------------+--------------------------------------------
//  s_*      | in        | s_tvalid/s_tready | tuser req_type, tdata a, b and scalar
//  m_*      | out       | m_tvalid/m_tready | tdata result vector and scalar, tuser flags
//
// The delay from input transfer to result is set by the square root
// pipeline (33 stages) in series with the per-lane divider pipelines (33 stages).
// One item is accepted every cycle unless the pipeline stalls; the whole pipeline advances as one.
// When the output register holds a result that is not taken, the pipeline and s_tready stall.
// Reset clears the valid bits only; data registers are not reset.
module vec3_arith_unit_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, scalar_in, from the lowest bit up
    input  logic [v3a_pkg::IN_DATA_W-1:0]     s_tdata,
    // req_type
    input  logic [v3a_pkg::OP_W-1:0]          s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // res_x, res_y, res_z, res_scalar, from the lowest bit up
    output logic [v3a_pkg::OUT_DATA_W-1:0]    m_tdata,
    // saturated, div_zero, from the lowest bit up
    output logic [1:0]                        m_tuser
);
    import v3a_pkg::*;

    logic                     adv;
    word_t                    in_a [3];
    word_t                    in_b [3];
    word_t                    in_s;
    op_t                      in_op;

    op_t                      op1_reg;
    word_t [2:0]              a1_reg;
    word_t                    s1_reg;
    logic signed [PROD_W-1:0] m1 [3];
    logic signed [PROD_W-1:0] m2 [3];
    logic signed [DATA_W:0]   sums [3];
    logic                     vp1_reg;
    logic                     vp2_reg;
    logic [SIDE_LEN-1:0]      vs_reg;
    logic                     out_valid_reg;

    side_t                    side_next;
    side_t                    side2_reg;
    logic [PROD_W-1:0]        sq_next;
    logic [PROD_W-1:0]        sq2_reg;
    side_t                    sp_reg [SIDE_LEN];
    side_t                    len_patch;
    logic [DATA_W-1:0]        root;
    logic [DATA_W-1:0]        quot [3];
    logic                     qovf [3];
    logic [DATA_W-1:0]        den_sel;

    side_t                    fin;
    word_t [2:0]              res_vec;
    word_t                    res_sc;
    logic                     res_sat;
    logic                     res_dz;
    logic [OUT_DATA_W-1:0]    tdata_reg;
    logic [1:0]               tuser_reg;

    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = adv;
    assign in_op    = op_t'(s_tuser);
    assign in_s     = s_tdata[6*DATA_W +: DATA_W];

    for (genvar i = 0; i < 3; i++)
    begin : g_lane
        assign in_a[i] = s_tdata[i*DATA_W +: DATA_W];
        assign in_b[i] = s_tdata[(i+3)*DATA_W +: DATA_W];

        v3a_lane u_lane (
            .clk     (clk),
            .en      (adv),
            .op      (in_op),
            .a_self  (in_a[i]),
            .b_self  (in_b[i]),
            .a_nxt   (in_a[(i+1)%3]),
            .b_nxt   (in_b[(i+1)%3]),
            .a_nn    (in_a[(i+2)%3]),
            .b_nn    (in_b[(i+2)%3]),
            .s_in    (in_s),
            .m1_reg  (m1[i]),
            .m2_reg  (m2[i]),
            .sum_reg (sums[i])
        );

        v3a_div u_div (
            .clk     (clk),
            .en      (adv),
            .num_mag (mag(sp_reg[SQRT_STEPS].a[i])),
            .den     (den_sel),
            .quot    (quot[i]),
            .ovf     (qovf[i])
        );
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            op1_reg <= in_op;
            s1_reg  <= in_s;
            for (int i = 0; i < 3; i++)
                a1_reg[i] <= in_a[i];
        end
    end

    // Merge stage: per-lane rounding and saturation, and the sum across lanes.
    always_comb
    begin
        logic signed [ACC_W-1:0] acc;
        satw_t                   r;

        acc               = ACC_W'(m1[0]) + ACC_W'(m1[1]) + ACC_W'(m1[2]);
        sq_next           = acc[PROD_W-1:0];
        side_next         = '0;
        side_next.op      = op1_reg;
        side_next.a       = a1_reg;
        side_next.s       = s1_reg;
        side_next.sq_zero = (sq_next == '0);
        for (int i = 0; i < 3; i++)
        begin
            r = '0;
            case (op1_reg)
                OP_ADD, OP_SUB: r = sat_acc(ACC_W'(sums[i]));
                OP_SCALE:       r = sat_acc(rnd_shift(ACC_W'(m1[i])));
                OP_CROSS:       r = sat_acc(rnd_shift(ACC_W'(m1[i]) - ACC_W'(m2[i])));
                default:        r = '0;
            endcase
            side_next.vec[i] = r.val;
            side_next.vsat   = side_next.vsat | r.sat;
        end
        if (op1_reg == OP_DOT || op1_reg == OP_LENSQ)
        begin
            r               = sat_acc(rnd_shift(acc));
            side_next.sc    = r.val;
            side_next.scsat = r.sat;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side2_reg <= side_next;
            sq2_reg   <= sq_next;
        end
    end

    v3a_sqrt u_sqrt (
        .clk      (clk),
        .en       (adv),
        .rad      (sq2_reg),
        .root_reg (root)
    );

    // The rounded root arrives alongside this side stage; length results are filled in here.
    always_comb
    begin
        len_patch = sp_reg[SQRT_STEPS];
        if (len_patch.op == OP_LEN || len_patch.op == OP_NORM)
        begin
            len_patch.scsat = root[DATA_W-1];
            len_patch.sc    = root[DATA_W-1] ? WORD_MAX : word_t'(root);
        end
        den_sel = (sp_reg[SQRT_STEPS].op == OP_DIV) ? mag(sp_reg[SQRT_STEPS].s) : root;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sp_reg[0] <= side2_reg;
            for (int k = 1; k < SIDE_LEN; k++)
                if (k != SQRT_STEPS+1)
                    sp_reg[k] <= sp_reg[k-1];
            sp_reg[SQRT_STEPS+1] <= len_patch;
        end
    end

    // Final stage: quotient clamping, divide by zero and zero-length cases.
    always_comb
    begin
        satw_t r;

        fin     = sp_reg[SIDE_LEN-1];
        res_vec = fin.vec;
        res_sc  = fin.sc;
        res_sat = fin.vsat | fin.scsat;
        res_dz  = 1'b0;
        r       = '0;
        case (fin.op)
            OP_DIV:
            begin
                if (fin.s == '0)
                begin
                    res_dz  = 1'b1;
                    res_sat = 1'b0;
                    for (int i = 0; i < 3; i++)
                    begin
                        if (fin.a[i][DATA_W-1])
                            res_vec[i] = WORD_MIN;
                        else if (fin.a[i] != '0)
                            res_vec[i] = WORD_MAX;
                        else
                            res_vec[i] = '0;
                    end
                end
                else
                begin
                    res_sat = 1'b0;
                    for (int i = 0; i < 3; i++)
                    begin
                        r = quot_clamp(quot[i], qovf[i],
                                       fin.a[i][DATA_W-1] ^ fin.s[DATA_W-1]);
                        res_vec[i] = r.val;
                        res_sat    = res_sat | r.sat;
                    end
                end
            end
            OP_NORM:
            begin
                if (fin.sq_zero)
                begin
                    res_vec = fin.a;
                    res_sc  = '0;
                    res_sat = 1'b0;
                end
                else
                begin
                    res_sat = fin.scsat;
                    for (int i = 0; i < 3; i++)
                    begin
                        r = quot_clamp(quot[i], qovf[i], fin.a[i][DATA_W-1]);
                        res_vec[i] = r.val;
                        res_sat    = res_sat | r.sat;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tdata_reg <= {res_sc, res_vec[2], res_vec[1], res_vec[0]};
            tuser_reg <= {res_dz, res_sat};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vp1_reg       <= 1'b0;
            vp2_reg       <= 1'b0;
            vs_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vp1_reg       <= s_tvalid;
            vp2_reg       <= vp1_reg;
            vs_reg        <= {vs_reg[SIDE_LEN-2:0], vp2_reg};
            out_valid_reg <= vs_reg[SIDE_LEN-1];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = tdata_reg;
    assign m_tuser  = tuser_reg;

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |-> !s_tready)
        else $error("input taken while the output is stalled");

    a_dz_not_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(tuser_reg[0] && tuser_reg[1]))
        else $error("divide by zero and saturation flagged together");

    a_out_from_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(vs_reg[SIDE_LEN-1]))
        else $error("result valid without an item at the pipeline end");

    a_pipe_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vs_reg))
        else $error("pipeline moved during a stall");

endmodule

/* hdl/v3a_lane.sv */
// One vector lane: adder and the two registered multipliers for its component.
module v3a_lane (
    input  logic                              clk,
    input  logic                              en,
    input  v3a_pkg::op_t                      op,
    input  v3a_pkg::word_t                    a_self,
    input  v3a_pkg::word_t                    b_self,
    input  v3a_pkg::word_t                    a_nxt,
    input  v3a_pkg::word_t                    b_nxt,
    input  v3a_pkg::word_t                    a_nn,
    input  v3a_pkg::word_t                    b_nn,
    input  v3a_pkg::word_t                    s_in,
    output logic signed [v3a_pkg::PROD_W-1:0] m1_reg,
    output logic signed [v3a_pkg::PROD_W-1:0] m2_reg,
    output logic signed [v3a_pkg::DATA_W:0]   sum_reg
);
    import v3a_pkg::*;

    word_t                    x1;
    word_t                    y1;
    logic signed [PROD_W-1:0] m1_next;
    logic signed [PROD_W-1:0] m2_next;
    logic signed [DATA_W:0]   sum_next;

    // The first multiplier is shared by scale, dot, cross and the squared terms.
    always_comb
    begin
        x1 = a_self;
        y1 = a_self;
        case (op)
            OP_SCALE: y1 = s_in;
            OP_DOT:   y1 = b_self;
            OP_CROSS:
            begin
                x1 = a_nxt;
                y1 = b_nn;
            end
            default: ;
        endcase
        m1_next = PROD_W'(x1) * PROD_W'(y1);
        m2_next = PROD_W'(a_nn) * PROD_W'(b_nxt);
        if (op == OP_SUB)
            sum_next = (DATA_W+1)'(a_self) - (DATA_W+1)'(b_self);
        else
            sum_next = (DATA_W+1)'(a_self) + (DATA_W+1)'(b_self);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1_reg  <= m1_next;
            m2_reg  <= m2_next;
            sum_reg <= sum_next;
        end
    end

endmodule

/* hdl/v3a_sqrt.sv */
// Pipelined integer square root, one root bit per stage, rounded to nearest at the end.
module v3a_sqrt (
    input  logic                         clk,
    input  logic                         en,
    input  logic [v3a_pkg::PROD_W-1:0]   rad,
    output logic [v3a_pkg::DATA_W-1:0]   root_reg
);
    import v3a_pkg::*;

    localparam int REM_W = DATA_W + 1;

    logic [REM_W-1:0]  rem_reg  [SQRT_STEPS];
    logic [DATA_W-1:0] rt_reg   [SQRT_STEPS];
    logic [PROD_W-1:0] rad_reg  [SQRT_STEPS];
    logic [REM_W-1:0]  rem_next [SQRT_STEPS];
    logic [DATA_W-1:0] rt_next  [SQRT_STEPS];
    logic [PROD_W-1:0] rad_next [SQRT_STEPS];
    logic [DATA_W-1:0] root_next;

    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_step
        logic [REM_W-1:0]  rem_in;
        logic [DATA_W-1:0] rt_in;
        logic [PROD_W-1:0] rad_in;
        logic [REM_W+1:0]  t;
        logic [REM_W+1:0]  trial;
        logic              ge;

        if (k == 0)
        begin : g_first
            assign rem_in = '0;
            assign rt_in  = '0;
            assign rad_in = rad;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign rt_in  = rt_reg[k-1];
            assign rad_in = rad_reg[k-1];
        end

        assign t           = {rem_in, rad_in[PROD_W-1 -: 2]};
        assign trial       = {1'b0, rt_in, 2'b01};
        assign ge          = (t >= trial);
        assign rem_next[k] = ge ? REM_W'(t - trial) : REM_W'(t);
        assign rt_next[k]  = {rt_in[DATA_W-2:0], ge};
        assign rad_next[k] = {rad_in[PROD_W-3:0], 2'b00};
    end

    // The final remainder is rad - root^2; above root means round up.
    assign root_next = rt_reg[SQRT_STEPS-1]
                     + DATA_W'(rem_reg[SQRT_STEPS-1] > {1'b0, rt_reg[SQRT_STEPS-1]});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < SQRT_STEPS; i++)
            begin
                rem_reg[i] <= rem_next[i];
                rt_reg[i]  <= rt_next[i];
                rad_reg[i] <= rad_next[i];
            end
            root_reg <= root_next;
        end
    end

endmodule

/* hdl/v3a_div.sv */
// Pipelined rounded divider of a magnitude by a magnitude, one quotient bit per stage.
module v3a_div (
    input  logic                         clk,
    input  logic                         en,
    input  logic [v3a_pkg::DATA_W-1:0]   num_mag,
    input  logic [v3a_pkg::DATA_W-1:0]   den,
    output logic [v3a_pkg::DATA_W-1:0]   quot,
    output logic                         ovf
);
    import v3a_pkg::*;

    localparam int HI_W = NUM_W - DATA_W;

    logic [DATA_W-1:0] rem_reg   [DIV_STEPS+1];
    logic [DATA_W-1:0] word_reg  [DIV_STEPS+1];
    logic [DATA_W-1:0] den_reg   [DIV_STEPS+1];
    logic              ovf_reg   [DIV_STEPS+1];
    logic [DATA_W-1:0] rem_next  [DIV_STEPS+1];
    logic [DATA_W-1:0] word_next [DIV_STEPS+1];
    logic [NUM_W-1:0]  num_full;
    logic [HI_W-1:0]   hi;

    // Adding half the divisor makes the truncating division round half away from zero.
    // A high part at or above the divisor means the quotient needs more than DATA_W bits.
    assign num_full     = (NUM_W'(num_mag) << FRAC_BITS) + NUM_W'(den >> 1);
    assign hi           = num_full[NUM_W-1:DATA_W];
    assign rem_next[0]  = DATA_W'(hi);
    assign word_next[0] = num_full[DATA_W-1:0];

    for (genvar k = 1; k <= DIV_STEPS; k++)
    begin : g_step
        logic [DATA_W:0] t;
        logic            ge;

        assign t            = {rem_reg[k-1], word_reg[k-1][DATA_W-1]};
        assign ge           = (t >= {1'b0, den_reg[k-1]});
        assign rem_next[k]  = ge ? DATA_W'(t - {1'b0, den_reg[k-1]}) : t[DATA_W-1:0];
        assign word_next[k] = {word_reg[k-1][DATA_W-2:0], ge};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= rem_next[0];
            word_reg[0] <= word_next[0];
            den_reg[0]  <= den;
            ovf_reg[0]  <= (DATA_W'(hi) >= den);
            for (int i = 1; i <= DIV_STEPS; i++)
            begin
                rem_reg[i]  <= rem_next[i];
                word_reg[i] <= word_next[i];
                den_reg[i]  <= den_reg[i-1];
                ovf_reg[i]  <= ovf_reg[i-1];
            end
        end
    end

    assign quot = word_reg[DIV_STEPS];
    assign ovf  = ovf_reg[DIV_STEPS];

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the three-component fixed-point vector unit.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import v3a_pkg::*;

    typedef struct {
        logic [OP_W-1:0] op;
        word_t           a [3];
        word_t           b [3];
        word_t           s;
    } vec_req_t;

    typedef struct {
        word_t v [3];
        word_t sc;
        logic  sat;
        logic  dz;
    } vec_res_t;

    typedef struct {
        vec_req_t req;
        logic     fixed;
        vec_res_t res;
    } stim_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [OP_W-1:0]       s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [1:0]            m_tuser;

    vec_res_t  pending_results [$];
    stim_row_t vec_table [$];
    int        error_count;
    int        send_idle_pct;
    int        recv_stall_pct;
    longint    cycle_count;

    localparam longint CYCLE_LIMIT = 64'd4000000;

    vec3_arith_unit_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic longint clamp_word(input longint v, inout logic sat);
        if (v > 64'sd2147483647)
        begin
            sat = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            sat = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // The sum of three 64-bit products fits easily in 70 bits.
    function automatic longint round_products(input logic signed [69:0] sum);
        logic signed [69:0] t;
        logic signed [69:0] q;
        t = sum + (70'sd1 <<< (FRAC_BITS - 1));
        q = t >>> FRAC_BITS;
        if (q > 70'sd4611686018427387903)
            return 64'sd4611686018427387903;
        if (q < -70'sd4611686018427387904)
            return -64'sd4611686018427387904;
        return longint'(q);
    endfunction

    function automatic longint quot_round(input logic [63:0] num, input logic [63:0] den,
                                          input logic neg, inout logic sat);
        logic [63:0] q;
        q = (num + den / 2) / den;
        if (neg)
        begin
            if (q > 64'd2147483648)
            begin
                sat = 1'b1;
                return -64'sd2147483648;
            end
            return -longint'(q);
        end
        if (q > 64'd2147483647)
        begin
            sat = 1'b1;
            return 64'sd2147483647;
        end
        return longint'(q);
    endfunction

    function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
        logic [63:0] r;
        logic [63:0] bitv;
        r = 0;
        bitv = 64'd1 << 62;
        while (bitv > x)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (x >= r + bitv)
            begin
                x = x - (r + bitv);
                r = (r >> 1) + bitv;
            end
            else
                r = r >> 1;
            bitv = bitv >> 2;
        end
        return r;
    endfunction

    function automatic vec_res_t vector_result(input vec_req_t q);
        vec_res_t r;
        longint a [3];
        longint b [3];
        longint s;
        longint v [3];
        longint sc;
        logic [63:0] sq;
        logic [63:0] m;
        logic [63:0] rt;
        logic signed [69:0] acc;
        logic sat;
        logic dz;
        int j;
        int k;
        sat = 1'b0;
        dz = 1'b0;
        sc = 0;
        sq = 0;
        for (int i = 0; i < 3; i++)
        begin
            a[i] = q.a[i];
            b[i] = q.b[i];
            v[i] = 0;
            m = (a[i] < 0) ? -a[i] : a[i];
            sq = sq + m * m;
        end
        s = q.s;
        case (q.op)
            OP_ADD:
                for (int i = 0; i < 3; i++) v[i] = clamp_word(a[i] + b[i], sat);
            OP_SUB:
                for (int i = 0; i < 3; i++) v[i] = clamp_word(a[i] - b[i], sat);
            OP_SCALE:
                for (int i = 0; i < 3; i++)
                    v[i] = clamp_word(round_products(70'(a[i] * s)), sat);
            OP_DIV:
                if (s == 0)
                begin
                    dz = 1'b1;
                    for (int i = 0; i < 3; i++)
                        v[i] = a[i] > 0 ? 64'sd2147483647 :
                               (a[i] < 0 ? -64'sd2147483648 : 0);
                end
                else
                    for (int i = 0; i < 3; i++)
                        v[i] = quot_round(((a[i] < 0) ? -a[i] : a[i]) << FRAC_BITS,
                                          (s < 0) ? -s : s, (a[i] < 0) != (s < 0), sat);
            OP_DOT:
            begin
                acc = 0;
                for (int i = 0; i < 3; i++) acc = acc + 70'(a[i] * b[i]);
                sc = clamp_word(round_products(acc), sat);
            end
            OP_CROSS:
                for (int i = 0; i < 3; i++)
                begin
                    j = (i + 1) % 3;
                    k = (i + 2) % 3;
                    acc = 70'(a[j] * b[k]) - 70'(a[k] * b[j]);
                    v[i] = clamp_word(round_products(acc), sat);
                end
            OP_LENSQ:
            begin
                m = (sq + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
                if (m > 64'd2147483647)
                begin
                    sat = 1'b1;
                    sc = 64'sd2147483647;
                end
                else
                    sc = longint'(m);
            end
            OP_LEN, OP_NORM:
            begin
                rt = floor_sqrt(sq);
                if (sq - rt * rt > rt)
                    rt = rt + 1;
                if (rt > 64'd2147483647)
                begin
                    sat = 1'b1;
                    sc = 64'sd2147483647;
                end
                else
                    sc = longint'(rt);
                if (q.op == OP_NORM)
                begin
                    if (sq == 0)
                    begin
                        for (int i = 0; i < 3; i++) v[i] = a[i];
                        sc = 0;
                    end
                    else
                        for (int i = 0; i < 3; i++)
                            v[i] = quot_round(((a[i] < 0) ? -a[i] : a[i]) << FRAC_BITS,
                                              rt, a[i] < 0, sat);
                end
            end
            default: ;
        endcase
        for (int i = 0; i < 3; i++) r.v[i] = word_t'(v[i]);
        r.sc = word_t'(sc);
        r.sat = sat;
        r.dz = dz;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
        error_count++;
    endtask

    function automatic word_t rand_word();
        case ($urandom_range(0, 9))
            0: return WORD_MAX;
            1: return WORD_MIN;
            2: return word_t'($urandom_range(0, 8)) - 4;
            3, 4: return word_t'(int'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
            5: return word_t'($urandom) >>> $urandom_range(0, 31);
            default: return word_t'($urandom);
        endcase
    endfunction

    function automatic vec_req_t rand_req();
        vec_req_t q;
        q.op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(9, 15))
                                             : 4'($urandom_range(OP_ADD, OP_NORM));
        for (int i = 0; i < 3; i++)
        begin
            q.a[i] = rand_word();
            q.b[i] = rand_word();
        end
        q.s = ($urandom_range(0, 9) == 0) ? word_t'(0) : rand_word();
        if ($urandom_range(0, 14) == 0)
            for (int i = 0; i < 3; i++) q.a[i] = 0;
        return q;
    endfunction

    function automatic vec_req_t mk_req(input logic [OP_W-1:0] op, input word_t ax,
                                        input word_t ay, input word_t az, input word_t bx,
                                        input word_t by, input word_t bz, input word_t s);
        vec_req_t q;
        q.op = op;
        q.a[0] = ax; q.a[1] = ay; q.a[2] = az;
        q.b[0] = bx; q.b[1] = by; q.b[2] = bz;
        q.s = s;
        return q;
    endfunction

    function automatic vec_res_t mk_res(input word_t x, input word_t y, input word_t z,
                                        input word_t sc, input logic sat, input logic dz);
        vec_res_t r;
        r.v[0] = x; r.v[1] = y; r.v[2] = z;
        r.sc = sc; r.sat = sat; r.dz = dz;
        return r;
    endfunction

    task automatic add_row(input vec_req_t q, input logic fixed, input vec_res_t r);
        stim_row_t row;
        row.req = q;
        row.fixed = fixed;
        row.res = r;
        vec_table.push_back(row);
    endtask

    task automatic build_table();
        word_t one;
        vec_res_t none;
        one = word_t'(32'h0001_0000);
        none = mk_res(0, 0, 0, 0, 0, 0);
        add_row(mk_req(OP_ADD, WORD_MAX, WORD_MIN, 1, 1, -1, 2, 0), 1'b1,
                mk_res(WORD_MAX, WORD_MIN, 3, 0, 1, 0));
        add_row(mk_req(OP_SUB, WORD_MIN, WORD_MAX, 0, 1, -1, WORD_MIN, 0), 1'b1,
                mk_res(WORD_MIN, WORD_MAX, WORD_MAX, 0, 1, 0));
        add_row(mk_req(OP_SCALE, one, -one, WORD_MAX, 0, 0, 0, one), 1'b1,
                mk_res(one, -one, WORD_MAX, 0, 0, 0));
        add_row(mk_req(OP_SCALE, WORD_MAX, WORD_MIN, 3, 0, 0, 0, WORD_MAX), 1'b0, none);
        add_row(mk_req(OP_DIV, 5, -5, 0, 0, 0, 0, 0), 1'b1,
                mk_res(WORD_MAX, WORD_MIN, 0, 0, 0, 1));
        add_row(mk_req(OP_DIV, WORD_MAX, WORD_MIN, 3, 0, 0, 0, 1), 1'b0, none);
        add_row(mk_req(OP_DIV, WORD_MIN, one, -one, 0, 0, 0, -1), 1'b0, none);
        add_row(mk_req(OP_DIV, 3, -3, 1, 0, 0, 0, 32'sh0002_0000), 1'b0, none);
        add_row(mk_req(OP_DOT, WORD_MAX, WORD_MAX, WORD_MAX,
                       WORD_MAX, WORD_MAX, WORD_MAX, 0), 1'b0, none);
        add_row(mk_req(OP_DOT, one, one, one, 1, -1, 1, 0), 1'b0, none);
        add_row(mk_req(OP_CROSS, one, 0, 0, 0, one, 0, 0), 1'b1,
                mk_res(0, 0, one, 0, 0, 0));
        add_row(mk_req(OP_CROSS, WORD_MIN, WORD_MAX, WORD_MIN,
                       WORD_MAX, WORD_MIN, WORD_MAX, 0), 1'b0, none);
        add_row(mk_req(OP_LENSQ, WORD_MIN, WORD_MIN, WORD_MIN, 0, 0, 0, 0), 1'b1,
                mk_res(0, 0, 0, WORD_MAX, 1, 0));
        add_row(mk_req(OP_LENSQ, 1, 1, 256, 0, 0, 0, 0), 1'b0, none);
        add_row(mk_req(OP_LEN, WORD_MIN, WORD_MIN, WORD_MIN, 0, 0, 0, 0), 1'b0, none);
        add_row(mk_req(OP_LEN, 3, 4, 0, 0, 0, 0, 0), 1'b1, mk_res(0, 0, 0, 5, 0, 0));
        add_row(mk_req(OP_NORM, 0, 0, 0, 7, 7, 7, 7), 1'b1, none);
        add_row(mk_req(OP_NORM, WORD_MIN, WORD_MAX, 1, 0, 0, 0, 0), 1'b0, none);
        add_row(mk_req(OP_NORM, 0, -1, 0, 0, 0, 0, 0), 1'b0, none);
        add_row(mk_req(OP_NORM, 3, -4, 0, 0, 0, 0, 0), 1'b0, none);
        add_row(mk_req(4'd9, one, one, one, one, one, one, one), 1'b1, none);
        add_row(mk_req(4'd15, -1, -1, -1, -1, -1, -1, -1), 1'b1, none);
    endtask

    // The valid line is dropped only while idling, so back-to-back items keep it high.
    task automatic send_item(input vec_req_t q, input vec_res_t expected);
        while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= q.op;
        s_tdata <= {q.s, q.b[2], q.b[1], q.b[0], q.a[2], q.a[1], q.a[0]};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_results.push_back(expected);
    endtask

    // Result side: count cycles, randomize stall, check each transfer.
    always @(posedge clk)
    begin
        vec_res_t e;
        logic [31:0] got [4];
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("testbench: errors");
            $finish;
        end
        else if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                for (int i = 0; i < 4; i++) got[i] = m_tdata[32*i +: 32];
                if (pending_results.size() == 0)
                    report_mismatch("unexpected transfer", got[0], 0);
                else
                begin
                    e = pending_results.pop_front();
                    for (int i = 0; i < 3; i++)
                        if (got[i] !== e.v[i])
                            report_mismatch($sformatf("res[%0d]", i), got[i], e.v[i]);
                    if (got[3] !== e.sc) report_mismatch("res_scalar", got[3], e.sc);
                    if (m_tuser[0] !== e.sat) report_mismatch("saturated", m_tuser[0], e.sat);
                    if (m_tuser[1] !== e.dz) report_mismatch("div_zero", m_tuser[1], e.dz);
                end
            end
            m_tready <= !(recv_stall_pct != 0 && $urandom_range(0, 99) < recv_stall_pct);
        end
    end

    initial
    begin
        vec_res_t r;
        int phase;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        error_count = 0;
        cycle_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        build_table();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (vec_table[i])
        begin
            r = vec_table[i].fixed ? vec_table[i].res : vector_result(vec_table[i].req);
            // The zero vector passes through normalise unchanged.
            if (vec_table[i].fixed && vec_table[i].req.op == OP_NORM)
                r = mk_res(0, 0, 0, 0, 0, 0);
            send_item(vec_table[i].req, r);
        end
        for (int n = 0; n < 1800; n++)
        begin
            phase = (n / 150) % 4;
            send_idle_pct = (phase == 1 || phase == 3) ? (phase == 1 ? 88 : 18) : 0;
            recv_stall_pct = (phase == 2 || phase == 3) ? (phase == 2 ? 88 : 18) : 0;
            begin
                vec_req_t q;
                q = rand_req();
                send_item(q, vector_result(q));
            end
        end
        s_tvalid <= 1'b0;
        recv_stall_pct = 0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (error_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end
endmodule
